[design/wgcs_pkg.sv]
// Package for the word-grouped conservative-update sketch core.
// Sizes, slot layout tables and controller/datapath interface structs.
// Used by the datapath, controller and top level; no dependencies.
package wgcs_pkg;

  localparam int WORDS             = 1024;
  localparam int COUNTERS_PER_WORD = 8;
  localparam int HASHED_WORDS      = 2;
  localparam int HASHED_COUNTERS   = 4;
  localparam int COUNTER_BITS      = 32;

  // fixed field widths of the stream items
  localparam int IDX_W     = 10;
  localparam int SLOT_IN_W = 3;
  localparam int EST_W     = 32;
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_CODES = 1 << SLOT_IN_W;

  localparam int WADDR_W = $clog2(WORDS);
  localparam int SLOT_W  = $clog2(COUNTERS_PER_WORD);

  // slots spread over the hashed words, first words take the remainder
  localparam int WORDS_USED = (HASHED_WORDS < 1) ? 1 : ((HASHED_WORDS > 2) ? 2 : HASHED_WORDS);
  localparam int CTRS_USED  = (HASHED_COUNTERS < 1) ? 1 :
                              ((HASHED_COUNTERS > NUM_SLOTS) ? NUM_SLOTS : HASHED_COUNTERS);
  localparam int PER_BASE   = CTRS_USED / WORDS_USED;
  localparam int PER_REST   = CTRS_USED - PER_BASE * WORDS_USED;
  localparam int CNT_A      = PER_BASE + ((PER_REST > 0) ? 1 : 0);

  // word index folding: exact reciprocal for 10-bit indices
  localparam bit WORD_FOLD   = (WORDS < (1 << IDX_W));
  localparam int FOLD_SHIFT  = 20;
  localparam int FOLD_RECIP  = ((1 << FOLD_SHIFT) + WORDS - 1) / WORDS;
  localparam int FOLD_PROD_W = 32;
  localparam int FOLD_MUL_W  = 2 * IDX_W;

  typedef logic [SLOT_W-1:0]                           slot_t;
  typedef logic [COUNTER_BITS-1:0]                     ctr_t;
  typedef logic [COUNTERS_PER_WORD-1:0][COUNTER_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]                          waddr_t;
  typedef logic [SLOT_CODES-1:0][SLOT_W-1:0]           slot_map_t;

  localparam ctr_t CTR_MAX = '1;

  function automatic slot_map_t build_slot_map();
    slot_map_t m;
    for (int i = 0; i < SLOT_CODES; i++) begin
      m[i] = slot_t'(i % COUNTERS_PER_WORD);
    end
    return m;
  endfunction

  function automatic logic [NUM_SLOTS-1:0] build_used_mask();
    logic [NUM_SLOTS-1:0] m;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m[i] = (i < CTRS_USED);
    end
    return m;
  endfunction

  function automatic logic [NUM_SLOTS-1:0] build_b_mask();
    logic [NUM_SLOTS-1:0] m;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m[i] = (i >= CNT_A);
    end
    return m;
  endfunction

  localparam slot_map_t            SLOT_MAP  = build_slot_map();
  localparam logic [NUM_SLOTS-1:0] SLOT_USED = build_used_mask();
  localparam logic [NUM_SLOTS-1:0] SLOT_IN_B = build_b_mask();

  typedef struct packed {
    logic                               query;
    logic [IDX_W-1:0]                   idx_a;
    logic [IDX_W-1:0]                   idx_b;
    logic [NUM_SLOTS-1:0][SLOT_IN_W-1:0] slot;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic latch;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic calc_min;
    logic wr_a;
    logic wr_b;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic out_free;
  } stat_t;

endpackage

[design/wgcs_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
module wgcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/wgcs_datapath.sv]
// Datapath of the sketch core: item registers, counter word RAM, minimum,
// conservative increment and the result register. Uses wgcs_pkg, wgcs_ram.
module wgcs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wgcs_pkg::cmd_t        cmd,
  output wgcs_pkg::stat_t       stat,
  input  wgcs_pkg::item_t       item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [wgcs_pkg::EST_W-1:0] out_est
);

  logic                                   query_r;
  logic [wgcs_pkg::IDX_W-1:0]             raw_a_r, raw_b_r;
  logic [wgcs_pkg::IDX_W-1:0]             quo_a_r, quo_b_r;
  wgcs_pkg::slot_t [wgcs_pkg::NUM_SLOTS-1:0] slot_r;
  wgcs_pkg::word_t                        word_a_r, word_b_r;
  wgcs_pkg::ctr_t                         min_r, min_nxt;
  logic [wgcs_pkg::EST_W-1:0]             est_r, est_nxt;
  logic                                   out_valid_r;
  wgcs_pkg::waddr_t                       clr_cnt_r;

  logic [wgcs_pkg::IDX_W-1:0]             red_a, red_b;
  wgcs_pkg::waddr_t                       addr_a, addr_b;
  logic                                   same_word;
  wgcs_pkg::word_t                        new_a, new_b, rdata, wdata;
  wgcs_pkg::waddr_t                       waddr, raddr;
  logic                                   we;
  logic [63:0]                            min_wide;

  // word index fold: remainder from the registered quotient
  assign red_a = wgcs_pkg::WORD_FOLD ?
      raw_a_r - wgcs_pkg::IDX_W'(wgcs_pkg::FOLD_MUL_W'(quo_a_r) *
                                 wgcs_pkg::FOLD_MUL_W'(wgcs_pkg::WORDS)) : raw_a_r;
  assign red_b = wgcs_pkg::WORD_FOLD ?
      raw_b_r - wgcs_pkg::IDX_W'(wgcs_pkg::FOLD_MUL_W'(quo_b_r) *
                                 wgcs_pkg::FOLD_MUL_W'(wgcs_pkg::WORDS)) : raw_b_r;
  assign addr_a    = wgcs_pkg::waddr_t'(red_a);
  assign addr_b    = wgcs_pkg::waddr_t'(red_b);
  assign same_word = (addr_a == addr_b);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      query_r <= item.query;
      raw_a_r <= item.idx_a;
      raw_b_r <= item.idx_b;
      quo_a_r <= wgcs_pkg::IDX_W'((wgcs_pkg::FOLD_PROD_W'(item.idx_a) *
                 wgcs_pkg::FOLD_PROD_W'(wgcs_pkg::FOLD_RECIP)) >> wgcs_pkg::FOLD_SHIFT);
      quo_b_r <= wgcs_pkg::IDX_W'((wgcs_pkg::FOLD_PROD_W'(item.idx_b) *
                 wgcs_pkg::FOLD_PROD_W'(wgcs_pkg::FOLD_RECIP)) >> wgcs_pkg::FOLD_SHIFT);
      for (int n = 0; n < wgcs_pkg::NUM_SLOTS; n++) begin
        slot_r[n] <= wgcs_pkg::SLOT_MAP[item.slot[n]];
      end
    end
    if (cmd.cap_a) begin
      word_a_r <= rdata;
    end
    if (cmd.cap_b) begin
      word_b_r <= rdata;
    end
    if (cmd.calc_min) begin
      min_r <= min_nxt;
    end
    if (cmd.out_load) begin
      est_r <= est_nxt;
    end
  end

  // minimum over the addressed counters
  always_comb begin
    wgcs_pkg::ctr_t v;
    min_nxt = wgcs_pkg::CTR_MAX;
    for (int n = 0; n < wgcs_pkg::NUM_SLOTS; n++) begin
      v = wgcs_pkg::SLOT_IN_B[n] ? word_b_r[slot_r[n]] : word_a_r[slot_r[n]];
      if (wgcs_pkg::SLOT_USED[n] && (v < min_nxt)) begin
        min_nxt = v;
      end
    end
  end

  // conservative increment, one hit flag per counter so shared ones bump once
  always_comb begin
    logic hit_a, hit_b;
    new_a = word_a_r;
    new_b = word_b_r;
    for (int c = 0; c < wgcs_pkg::COUNTERS_PER_WORD; c++) begin
      hit_a = 1'b0;
      hit_b = 1'b0;
      for (int n = 0; n < wgcs_pkg::NUM_SLOTS; n++) begin
        if (wgcs_pkg::SLOT_USED[n] && (slot_r[n] == wgcs_pkg::slot_t'(c))) begin
          if (!wgcs_pkg::SLOT_IN_B[n] || same_word) begin
            hit_a = 1'b1;
          end
          if (wgcs_pkg::SLOT_IN_B[n] || same_word) begin
            hit_b = 1'b1;
          end
        end
      end
      if (hit_a && (word_a_r[c] == min_r) && (word_a_r[c] != wgcs_pkg::CTR_MAX)) begin
        new_a[c] = word_a_r[c] + wgcs_pkg::ctr_t'(1);
      end
      if (hit_b && (word_b_r[c] == min_r) && (word_b_r[c] != wgcs_pkg::CTR_MAX)) begin
        new_b[c] = word_b_r[c] + wgcs_pkg::ctr_t'(1);
      end
    end
  end

  // estimate saturates when counters are wider than the field
  assign min_wide = 64'(min_r);
  assign est_nxt  = (min_wide > 64'h0000_0000_FFFF_FFFF) ? '1 : min_wide[wgcs_pkg::EST_W-1:0];

  assign we    = cmd.clr | cmd.wr_a | cmd.wr_b;
  assign waddr = cmd.clr ? clr_cnt_r : (cmd.wr_b ? addr_b : addr_a);
  assign wdata = cmd.clr ? '0 : (cmd.wr_b ? new_b : new_a);
  assign raddr = cmd.rd_b ? addr_b : addr_a;

  wgcs_ram #(
    .WIDTH($bits(wgcs_pkg::word_t)),
    .DEPTH(wgcs_pkg::WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + wgcs_pkg::waddr_t'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last = (clr_cnt_r == wgcs_pkg::waddr_t'(wgcs_pkg::WORDS - 1));
  assign stat.is_query = query_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_est   = est_r;

endmodule

[design/wgcs_ctrl.sv]
// Controller of the sketch core: clearing sweep, read / minimum / write-back
// or result sequence per item. Uses wgcs_pkg.
module wgcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  wgcs_pkg::stat_t stat,
  output wgcs_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_CAPB  = 4'd4;
  localparam logic [3:0] S_MIN   = 4'd5;
  localparam logic [3:0] S_RES   = 4'd6;
  localparam logic [3:0] S_WRA   = 4'd7;
  localparam logic [3:0] S_WRB   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = 1'b1;
        if (in_valid) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
        state_nxt = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_MIN;
      end
      S_MIN: begin
        cmd.calc_min = 1'b1;
        state_nxt    = stat.is_query ? S_RES : S_WRA;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WRA: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/word_grouped_conservative_sketch_core.sv]
// Word-grouped conservative-update frequency sketch, top level.
// Sequencing: one item at a time; the counter word RAM serves words A and B
//   one at a time for read and write-back. A query waits in its result state
//   while the result register stays full.
// Output: out_tvalid is registered, set by the result load once the result
//   register is free.
// Reset: synchronous rst_n; afterwards a sweep over all WORDS (1024) words
//   zeroes the counter RAM, during which in_tready stays low.
module word_grouped_conservative_sketch_core (
  input  logic        clk,
  input  logic        rst_n,
  // input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] word_index_a, [19:10] word_index_b, [22:20] slot_zero,
  // [25:23] slot_one, [28:26] slot_two, [31:29] slot_three
  input  logic [31:0] in_tdata,
  // [0] opcode (0 insert, 1 query)
  input  logic        in_tuser,
  // result stream, queries only
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] estimate
  output logic [31:0] out_tdata
);

  wgcs_pkg::cmd_t  cmd;
  wgcs_pkg::stat_t stat;
  wgcs_pkg::item_t item;

  // unpack the input transfer
  assign item.query   = in_tuser;
  assign item.idx_a   = in_tdata[9:0];
  assign item.idx_b   = in_tdata[19:10];
  assign item.slot[0] = in_tdata[22:20];
  assign item.slot[1] = in_tdata[25:23];
  assign item.slot[2] = in_tdata[28:26];
  assign item.slot[3] = in_tdata[31:29];

  // sequencer: clear sweep, then read A, read B, min, then result or write-back
  wgcs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // counter RAM plus the min / increment logic and the output register,
  // which frees the sequencer while an estimate waits for out_tready
  wgcs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .item     (item),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_est  (out_tdata)
  );

  // a new estimate only appears through the result load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.out_load))
    else $error("result valid rose without a load");

  // write-back of word B always follows word A
  a_wr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_b |-> $past(cmd.wr_a))
    else $error("word B written without word A");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while busy");

  // nothing is written to the store while an item is being taken
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.wr_a || cmd.wr_b || cmd.clr))
    else $error("store write while accepting");

endmodule

[bench/tb_top.sv]
// Self-checking bench for word_grouped_conservative_sketch_core.
// A directed pass, random traffic under several idle/stall mixes, and a long
// output hold-off, all checked against an in-bench sketch predictor.
// Depends on design/wgcs_pkg.sv and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode carried on in_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } sk_op_e;

  // One input item; slots[0] is slot_zero
  typedef struct packed {
    sk_op_e          op;
    logic [9:0]      word_a;
    logic [9:0]      word_b;
    logic [3:0][2:0] slots;
  } sk_item_t;

  localparam int STORE_DEPTH = wgcs_pkg::WORDS * wgcs_pkg::COUNTERS_PER_WORD;
  localparam int HOT_KEYS    = 24;
  localparam int HOT_WORDS   = 8;
  // Drain margin past the last result, so a trailing insert can finish
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // Predictor state: one copy of every counter
  wgcs_pkg::ctr_t sketch_ctrs [STORE_DEPTH];
  logic [31:0] pending_estimates [$];
  int          mismatch_count = 0;

  // Traffic shaping, percentages per cycle
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;

  sk_item_t    hot_keys [HOT_KEYS];

  word_grouped_conservative_sketch_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-away guard
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Applies one item to the predicted sketch; returns the (clamped) minimum.
  function automatic logic [31:0] sketch_apply(sk_item_t it);
    int unsigned addr [4];
    int unsigned wsel [2];
    int          words_used;
    int          ctrs_used;
    int          per_base;
    int          per_rest;
    int          cnt;
    int          n;
    logic [63:0] minv;
    bit          seen;
    words_used = (wgcs_pkg::HASHED_WORDS < 1) ? 1 :
                 ((wgcs_pkg::HASHED_WORDS > 2) ? 2 : wgcs_pkg::HASHED_WORDS);
    ctrs_used  = (wgcs_pkg::HASHED_COUNTERS < 1) ? 1 :
                 ((wgcs_pkg::HASHED_COUNTERS > 4) ? 4 : wgcs_pkg::HASHED_COUNTERS);
    per_base   = ctrs_used / words_used;
    per_rest   = ctrs_used - per_base * words_used;
    wsel[0]    = it.word_a % wgcs_pkg::WORDS;
    wsel[1]    = it.word_b % wgcs_pkg::WORDS;
    n = 0;
    // Slots are consumed in order; leading words take the remainder
    for (int w = 0; w < words_used; w++) begin
      cnt = per_base + ((w < per_rest) ? 1 : 0);
      for (int j = 0; j < cnt && n < 4; j++) begin
        addr[n] = (wsel[w] * wgcs_pkg::COUNTERS_PER_WORD
                   + it.slots[n] % wgcs_pkg::COUNTERS_PER_WORD) % STORE_DEPTH;
        n++;
      end
    end
    minv = '1;
    for (int i = 0; i < n; i++) begin
      if (64'(sketch_ctrs[addr[i]]) < minv) minv = 64'(sketch_ctrs[addr[i]]);
    end
    if (it.op == OP_INSERT) begin
      // Conservative update: each distinct counter at the minimum goes up once
      for (int i = 0; i < n; i++) begin
        seen = 1'b0;
        for (int k = 0; k < i; k++) begin
          if (addr[k] == addr[i]) seen = 1'b1;
        end
        if (!seen && 64'(sketch_ctrs[addr[i]]) == minv &&
            sketch_ctrs[addr[i]] != wgcs_pkg::CTR_MAX)
          sketch_ctrs[addr[i]] = sketch_ctrs[addr[i]] + 1'b1;
      end
    end
    return (minv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : minv[31:0];
  endfunction

  function automatic sk_item_t mk_item(sk_op_e op, int wa, int wb,
                                       int s0, int s1, int s2, int s3);
    sk_item_t it;
    it.op       = op;
    it.word_a   = 10'(wa);
    it.word_b   = 10'(wb);
    it.slots[0] = 3'(s0);
    it.slots[1] = 3'(s1);
    it.slots[2] = 3'(s2);
    it.slots[3] = 3'(s3);
    return it;
  endfunction

  // Mostly hot keys over a few shared words so counters grow and overlap,
  // some with one slot perturbed; the rest is fully random.
  function automatic sk_item_t random_item();
    sk_item_t it;
    int       r;
    r = $urandom_range(99);
    if (r < 70) begin
      it = hot_keys[$urandom_range(HOT_KEYS - 1)];
      if ($urandom_range(9) == 0) it.slots[$urandom_range(3)] = 3'($urandom_range(7));
    end else begin
      it.word_a = 10'($urandom);
      it.word_b = 10'($urandom);
      it.slots  = 12'($urandom);
    end
    if ($urandom_range(99) < 35) it.op = OP_QUERY;
    else it.op = OP_INSERT;
    return it;
  endfunction

  // Sends one item; called and returns at a falling edge.
  task automatic send_item(sk_item_t it);
    logic [31:0] est;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.slots, it.word_b, it.word_a};
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
    est = sketch_apply(it);
    if (it.op == OP_QUERY) pending_estimates.push_back(est);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted estimate has been seen
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(int count, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_item(random_item());
    drain_results();
  endtask

  // Output side: random stalls, plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every estimate transfer is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_estimates.size() == 0) begin
        $error("estimate: unexpected transfer, actual %0d", out_tdata);
        mismatch_count++;
      end else begin
        if (out_tdata !== pending_estimates[0]) begin
          $error("estimate mismatch: expected %0d, actual %0d",
                 pending_estimates[0], out_tdata);
          mismatch_count++;
        end
        void'(pending_estimates.pop_front());
      end
    end
  end

  // Extremes of every field, shared counters and the conservative rule
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(mk_item(OP_QUERY,  0,    0,    0, 0, 0, 0));   // fresh store reads zero
    send_item(mk_item(OP_QUERY,  1023, 1023, 7, 7, 7, 7));
    send_item(mk_item(OP_INSERT, 0,    1023, 0, 7, 0, 7));
    send_item(mk_item(OP_QUERY,  0,    1023, 0, 7, 0, 7));
    send_item(mk_item(OP_INSERT, 0,    1023, 0, 7, 0, 7));
    send_item(mk_item(OP_QUERY,  0,    1023, 0, 7, 0, 7));
    // overlaps one counter already at two; only the minimum ones move
    send_item(mk_item(OP_INSERT, 0,    5,    0, 1, 2, 3));
    send_item(mk_item(OP_QUERY,  0,    5,    0, 1, 2, 3));
    send_item(mk_item(OP_QUERY,  0,    1023, 0, 7, 0, 7));
    // one counter addressed four times goes up once
    send_item(mk_item(OP_INSERT, 7,    7,    4, 4, 4, 4));
    send_item(mk_item(OP_QUERY,  7,    7,    4, 4, 4, 4));
    // both word indices equal, slots paired across the words
    send_item(mk_item(OP_INSERT, 9,    9,    1, 2, 1, 2));
    send_item(mk_item(OP_QUERY,  9,    9,    1, 2, 1, 2));
    send_item(mk_item(OP_INSERT, 3,    4,    6, 6, 6, 6));
    send_item(mk_item(OP_QUERY,  3,    4,    6, 6, 6, 6));
    send_item(mk_item(OP_QUERY,  3,    4,    6, 6, 5, 6));
    send_item(mk_item(OP_INSERT, 1023, 0,    7, 7, 0, 0));
    send_item(mk_item(OP_QUERY,  1023, 0,    7, 0, 0, 7));
    repeat (3) send_item(mk_item(OP_INSERT, 512, 511, 5, 2, 3, 4));
    send_item(mk_item(OP_QUERY,  512,  511,  5, 2, 3, 4));
    send_item(mk_item(OP_QUERY,  512,  0,    5, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_random_no_idle();
    run_random(400, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random(380, 77, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random(380, 0, 77);
  endtask

  task automatic test_random_both_idle();
    run_random(380, 21, 21);
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // result register fills and the block has to stall its input.
  task automatic test_output_hold_off();
    sk_item_t it;
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_req = 400;
    @(negedge clk);
    for (int i = 0; i < 40; i++) begin
      it = random_item();
      if (i % 2 == 0) it.op = OP_QUERY;
      send_item(it);
    end
    drain_results();
  endtask

  initial begin
    foreach (sketch_ctrs[i]) sketch_ctrs[i] = '0;
    // hot keys share a handful of words so their counters collide
    begin
      logic [9:0] hot_word_set [HOT_WORDS];
      foreach (hot_word_set[i]) hot_word_set[i] = 10'($urandom);
      foreach (hot_keys[i]) begin
        hot_keys[i].op     = OP_INSERT;
        hot_keys[i].word_a = hot_word_set[$urandom_range(HOT_WORDS - 1)];
        hot_keys[i].word_b = hot_word_set[$urandom_range(HOT_WORDS - 1)];
        hot_keys[i].slots  = 12'($urandom);
      end
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the post-reset clear sweep is covered by waiting on in_tready
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_hold_off();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/wgcs_pkg.sv
design/wgcs_ram.sv
design/wgcs_datapath.sv
design/wgcs_ctrl.sv
design/word_grouped_conservative_sketch_core.sv
bench/tb_top.sv
